// ===== sv/nfe_pkg.sv =====
package nfe_pkg;

   localparam logic [3:0] HeaderLength = 4'd5;
   localparam logic [2:0] HeaderLast = 3'(HeaderLength - 4'd1);

   localparam logic [7:0] CharStart = 8'h24;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharLf = 8'h0A;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 64;

   typedef enum logic [1:0] {
      REG_HEADER_TEXT = 2'd0,
      REG_REPEAT_INDEX = 2'd1,
      REG_FIELD_INDEX = 2'd2,
      REG_NONE = 2'd3
   } reg_index_type;

   localparam logic [39:0] HeaderTextReset = 40'd310581052737;
   localparam logic [7:0] RepeatIndexReset = 8'd0;
   localparam logic [4:0] FieldIndexReset = 5'd2;

endpackage

// ===== sv/nmea_field_extractor.sv =====
// Latency: a result word appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless the result word is stalled; the whole
// per-byte state update sits between the parser state registers and the result register.
// Reset (synchronous, active high) clears the parser state and the result
// valid flag and loads the default header, repeat index and field index.
module nmea_field_extractor
   import nfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_end_of_text,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_char_valid,
   output logic                    rsp_finished,
   output logic                    rsp_found,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic [39:0] header_text_ff;
   logic [7:0]  repeat_index_ff;
   logic [4:0]  field_index_ff;

   logic       in_header_ff, in_header_in;
   logic       after_start_ff, after_start_in;
   logic [2:0] header_pos_ff, header_pos_in;
   logic       match_ff, match_in;
   logic [7:0] occurrence_count_ff, occurrence_count_in;
   logic       in_data_ff, in_data_in;
   logic [5:0] comma_count_ff, comma_count_in;
   logic       line_cut_ff, line_cut_in;
   logic       any_emitted_ff, any_emitted_in;
   logic       search_done_ff, search_done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       char_valid_ff, char_valid_in;
   logic       finished_ff, finished_in;
   logic       found_ff, found_in;

   logic          accept;
   logic          csr_write;
   reg_index_type csr_index;
   logic [63:0]   header_ext;
   logic [7:0]    header_byte;
   logic          skip_rest;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      case (csr_index)
         REG_HEADER_TEXT: csr_prdata = {24'd0, header_text_ff};
         REG_REPEAT_INDEX: csr_prdata = {56'd0, repeat_index_ff};
         REG_FIELD_INDEX: csr_prdata = {59'd0, field_index_ff};
         default: csr_prdata = '0;
      endcase
   end

   // The result register only holds back new input while its word is stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   assign header_ext = {24'd0, header_text_ff};

   always_comb begin
      in_header_in = in_header_ff;
      after_start_in = after_start_ff;
      header_pos_in = header_pos_ff;
      match_in = match_ff;
      occurrence_count_in = occurrence_count_ff;
      in_data_in = in_data_ff;
      comma_count_in = comma_count_ff;
      line_cut_in = line_cut_ff;
      any_emitted_in = any_emitted_ff;
      search_done_in = search_done_ff;
      out_char_in = 8'd0;
      char_valid_in = 1'b0;
      finished_in = 1'b0;
      found_in = 1'b0;
      skip_rest = 1'b0;
      header_byte = header_ext[{header_pos_ff, 3'b000} +: 8];

      if (!search_done_ff) begin
         if (after_start_ff) begin
            after_start_in = 1'b0;
         end else if (req_in_byte == CharStart) begin
            in_header_in = 1'b1;
            after_start_in = 1'b1;
            header_pos_in = 3'd0;
            match_in = 1'b1;
            in_data_in = 1'b0;
            skip_rest = 1'b1;
         end

         if (!skip_rest) begin
            if (in_header_in) begin
               if (req_in_byte == CharComma || {1'b0, header_pos_in} >= HeaderLength) begin
                  in_header_in = 1'b0;
               end else begin
                  if (req_in_byte != header_byte) begin
                     match_in = 1'b0;
                  end
                  if (header_pos_in == HeaderLast) begin
                     in_header_in = 1'b0;
                     if (match_in) begin
                        if (occurrence_count_in == repeat_index_ff) begin
                           in_data_in = 1'b1;
                        end
                        if (occurrence_count_in != 8'd255) begin
                           occurrence_count_in = occurrence_count_in + 8'd1;
                        end
                     end
                  end
                  header_pos_in = header_pos_in + 3'd1;
               end
            end

            if (in_data_in) begin
               if (comma_count_in == {1'b0, field_index_ff} && req_in_byte != CharComma) begin
                  if (req_in_byte == CharCr || req_in_byte == CharLf) begin
                     line_cut_in = 1'b1;
                  end
                  if (!line_cut_in) begin
                     out_char_in = req_in_byte;
                     char_valid_in = 1'b1;
                     any_emitted_in = 1'b1;
                  end
               end
               if (req_in_byte == CharComma && comma_count_in != 6'd63) begin
                  comma_count_in = comma_count_in + 6'd1;
               end
               if (comma_count_in > {1'b0, field_index_ff}) begin
                  finished_in = 1'b1;
                  found_in = any_emitted_in;
                  search_done_in = 1'b1;
               end
            end
         end

         if (req_end_of_text && !finished_in) begin
            finished_in = 1'b1;
            found_in = any_emitted_in;
         end
      end

      if (req_end_of_text) begin
         in_header_in = 1'b0;
         after_start_in = 1'b0;
         header_pos_in = 3'd0;
         match_in = 1'b1;
         occurrence_count_in = 8'd0;
         in_data_in = 1'b0;
         comma_count_in = 6'd0;
         line_cut_in = 1'b0;
         any_emitted_in = 1'b0;
         search_done_in = 1'b0;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_text_ff <= HeaderTextReset;
         repeat_index_ff <= RepeatIndexReset;
         field_index_ff <= FieldIndexReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_HEADER_TEXT: header_text_ff <= csr_pwdata[39:0];
            REG_REPEAT_INDEX: repeat_index_ff <= csr_pwdata[7:0];
            REG_FIELD_INDEX: field_index_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff <= 1'b0;
         after_start_ff <= 1'b0;
         header_pos_ff <= 3'd0;
         match_ff <= 1'b1;
         occurrence_count_ff <= 8'd0;
         in_data_ff <= 1'b0;
         comma_count_ff <= 6'd0;
         line_cut_ff <= 1'b0;
         any_emitted_ff <= 1'b0;
         search_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_header_ff <= in_header_in;
            after_start_ff <= after_start_in;
            header_pos_ff <= header_pos_in;
            match_ff <= match_in;
            occurrence_count_ff <= occurrence_count_in;
            in_data_ff <= in_data_in;
            comma_count_ff <= comma_count_in;
            line_cut_ff <= line_cut_in;
            any_emitted_ff <= any_emitted_in;
            search_done_ff <= search_done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_char_ff <= out_char_in;
         char_valid_ff <= char_valid_in;
         finished_ff <= finished_in;
         found_ff <= found_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_finished = finished_ff;
   assign rsp_found = found_ff;

endmodule

// ===== tb/nmea_field_extractor_tb.sv =====
module nmea_field_extractor_tb;
   import nfe_pkg::*;

   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_word_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       finished;
      logic       found;
   } field_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_in_byte = 8'd0;
   logic                    req_end_of_text = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_out_char;
   logic                    rsp_char_valid;
   logic                    rsp_finished;
   logic                    rsp_found;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   nmea_field_extractor u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_finished    (rsp_finished),
      .rsp_found       (rsp_found),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_word_type  text_to_send[$];
   field_word_type expected_words[$];
   logic [7:0]     draft[$];
   text_word_type  next_word;
   field_word_type want;
   int             idle_pct = 0;
   int             mismatches = 0;
   int             cycle_count = 0;

   logic [39:0] cfg_header = HeaderTextReset;
   logic [7:0]  cfg_repeat = RepeatIndexReset;
   logic [4:0]  cfg_field = FieldIndexReset;

   logic        in_hdr = 1'b0;
   logic        after_dollar = 1'b0;
   logic [2:0]  hdr_pos = 3'd0;
   logic        hdr_ok = 1'b1;
   logic [7:0]  occ = 8'd0;
   logic        in_field = 1'b0;
   logic [5:0]  commas = 6'd0;
   logic        cut = 1'b0;
   logic        emitted = 1'b0;
   logic        done = 1'b0;

   task automatic predict_field_word(input logic [7:0] c, input logic eot);
      field_word_type r;
      logic           skip;
      r = '0;
      skip = 1'b0;
      if (!done) begin
         if (after_dollar) begin
            after_dollar = 1'b0;
         end else if (c == CharStart) begin
            in_hdr = 1'b1;
            after_dollar = 1'b1;
            hdr_pos = 3'd0;
            hdr_ok = 1'b1;
            in_field = 1'b0;
            skip = 1'b1;
         end
         if (!skip) begin
            if (in_hdr) begin
               if (c == CharComma || hdr_pos >= HeaderLength) begin
                  in_hdr = 1'b0;
               end else begin
                  if (c != cfg_header[hdr_pos*8 +: 8]) hdr_ok = 1'b0;
                  if (hdr_pos == HeaderLast) begin
                     in_hdr = 1'b0;
                     if (hdr_ok) begin
                        if (occ == cfg_repeat) in_field = 1'b1;
                        if (occ != 8'hFF) occ = occ + 8'd1;
                     end
                  end
                  hdr_pos = hdr_pos + 3'd1;
               end
            end
            if (in_field) begin
               if (commas == {1'b0, cfg_field} && c != CharComma) begin
                  if (c == CharCr || c == CharLf) cut = 1'b1;
                  if (!cut) begin
                     r.out_char = c;
                     r.char_valid = 1'b1;
                     emitted = 1'b1;
                  end
               end
               if (c == CharComma && commas != 6'd63) commas = commas + 6'd1;
               if (commas > cfg_field) begin
                  r.finished = 1'b1;
                  r.found = emitted;
                  done = 1'b1;
               end
            end
         end
         if (eot && !r.finished) begin
            r.finished = 1'b1;
            r.found = emitted;
         end
      end
      if (eot) begin
         in_hdr = 1'b0;
         after_dollar = 1'b0;
         hdr_pos = 3'd0;
         hdr_ok = 1'b1;
         occ = 8'd0;
         in_field = 1'b0;
         commas = 6'd0;
         cut = 1'b0;
         emitted = 1'b0;
         done = 1'b0;
      end
      expected_words.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_field_word(req_in_byte, req_end_of_text);
         end
         if (!req_valid || !req_stall) begin
            if (text_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_word = text_to_send.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= next_word.text;
               req_end_of_text <= next_word.eot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string what, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, what, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, actual char %h valid %b",
                        $time, rsp_out_char, rsp_char_valid);
            end else begin
               want = expected_words.pop_front();
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("char_valid", want.char_valid, rsp_char_valid);
               check_field("finished", want.finished, rsp_finished);
               check_field("found", want.found, rsp_found);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      logic [63:0] stored;
      case (idx)
         REG_HEADER_TEXT: begin
            stored = {24'd0, value[39:0]};
         end
         REG_REPEAT_INDEX: begin
            stored = {56'd0, value[7:0]};
         end
         default: begin
            stored = {59'd0, value[4:0]};
         end
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HEADER_TEXT: begin
            cfg_header = stored[39:0];
         end
         REG_REPEAT_INDEX: begin
            cfg_repeat = stored[7:0];
         end
         default: begin
            cfg_field = stored[4:0];
         end
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored) begin
         mismatches++;
         $display("%0t: register %s read expected %h actual %h",
                  $time, idx.name(), stored, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      while (text_to_send.size() != 0 || req_valid || expected_words.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [39:0] random_header();
      logic [39:0] h;
      for (int k = 0; k < 5; k++) h[k*8 +: 8] = 8'($urandom_range(8'h41, 8'h5A));
      return h;
   endfunction

   function automatic logic [7:0] text_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return 8'($urandom_range(8'h30, 8'h7A));
      if (roll < 84) return CharCr;
      if (roll < 88) return CharLf;
      return 8'($urandom_range(0, 255));
   endfunction

   // The draft becomes one buffer: its last word carries the end-of-text flag.
   task automatic send_draft();
      foreach (draft[i]) text_to_send.push_back('{draft[i], i == draft.size() - 1});
      draft.delete();
   endtask

   task automatic add_sentence(input int nfields);
      int roll;
      int bad;
      int stop;
      draft.push_back(CharStart);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         stop = $urandom_range(0, 4);
         for (int k = 0; k < stop; k++) draft.push_back(cfg_header[k*8 +: 8]);
         draft.push_back(CharComma);
      end else begin
         bad = (roll < 25) ? $urandom_range(0, 4) : 5;
         for (int k = 0; k < 5; k++) begin
            draft.push_back(k == bad ? 8'($urandom_range(0, 255)) : cfg_header[k*8 +: 8]);
         end
      end
      for (int f = 0; f < nfields; f++) begin
         draft.push_back(CharComma);
         repeat ($urandom_range(0, 3)) draft.push_back(text_char());
      end
      if ($urandom_range(0, 2) == 0) begin
         draft.push_back(CharCr);
         draft.push_back(CharLf);
      end
   endtask

   task automatic stream_text(input int words, input int max_sentences, input int max_fields);
      int queued;
      int drop;
      queued = 0;
      while (queued < words) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, max_sentences)) begin
               if ($urandom_range(0, 9) == 0) draft.push_back(8'($urandom_range(0, 255)));
               add_sentence($urandom_range(0, max_fields));
            end
            if ($urandom_range(0, 9) == 0) begin
               drop = $urandom_range(0, draft.size() - 1);
               repeat (drop) void'(draft.pop_back());
            end
         end
         queued += draft.size();
         send_draft();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      draft = '{8'h00, 8'hFF};
      send_draft();
      draft = '{CharStart, CharStart, CharComma, 8'h51};
      send_draft();
      draft.push_back(CharStart);
      for (int k = 0; k < 5; k++) draft.push_back(HeaderTextReset[k*8 +: 8]);
      draft = {draft, CharComma, 8'h41, CharComma, 8'h78, 8'h79, CharCr, 8'h7A, CharLf,
               CharComma, 8'h71, 8'h72};
      send_draft();
      settle();

      csr_write(REG_HEADER_TEXT, {24'd0, random_header()});
      csr_write(REG_REPEAT_INDEX, 64'd0);
      csr_write(REG_FIELD_INDEX, 64'd1);
      stream_text(120, 3, 4);
      settle();

      idle_pct = 15;
      csr_write(REG_HEADER_TEXT, 64'd0);
      csr_write(REG_REPEAT_INDEX, 64'd1);
      csr_write(REG_FIELD_INDEX, 64'd3);
      stream_text(40, 4, 6);
      settle();

      csr_write(REG_HEADER_TEXT, 64'hFF_FFFF_FFFF);
      csr_write(REG_REPEAT_INDEX, 64'd2);
      csr_write(REG_FIELD_INDEX, 64'd31);
      stream_text(60, 4, 34);
      settle();

      // Enough matching headers to push the occurrence count into saturation.
      csr_write(REG_HEADER_TEXT, {24'd0, HeaderTextReset});
      csr_write(REG_REPEAT_INDEX, 64'd255);
      csr_write(REG_FIELD_INDEX, 64'd2);
      repeat (258) begin
         draft.push_back(CharStart);
         for (int k = 0; k < 5; k++) draft.push_back(cfg_header[k*8 +: 8]);
      end
      draft = {draft, CharComma, 8'h61, CharComma, 8'h62, 8'h63, CharComma, 8'h64};
      send_draft();
      settle();

      repeat (2) begin
         csr_write(REG_HEADER_TEXT, {24'd0, random_header()});
         csr_write(REG_REPEAT_INDEX, 64'($urandom_range(0, 3)));
         csr_write(REG_FIELD_INDEX, 64'($urandom_range(1, 6)));
         stream_text(40, 5, 8);
         settle();
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
